[rtl/gff_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gff_pkg: shared types and constants for the grid flood fill core
// Grid geometry, command kinds and the record passed from front to back.
// ----------------------------------------------------------------------------
package gff_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int CNT_W    = 13;
    localparam int VAL_W    = 11;
    localparam int DIM_W    = 7;
    localparam int QCNT_W   = ADDR_W + 1;

    localparam logic [VAL_W-1:0] EMPTY_VAL = '1;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_WRITE = 2'd0;
    localparam kind_t KIND_READ  = 2'd1;
    localparam kind_t KIND_FILL  = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        kind_t             kind;
        logic              in_range;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [VAL_W-1:0]  value;
    } cmd_t;

endpackage
`default_nettype wire

[rtl/grid_flood_fill_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grid_flood_fill_core: tile grid with cell write, read and 4-connected fill
// Front end queues classified commands; back end runs them on the grid.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  s_      | s_valid / s_ready  | kind, col, row, tile_value
//  m_      | m_valid / m_ready  | read_value, cells_changed, in_range
//  cfg_    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  Write or out-of-range item: the result is registered straight from S_IDLE;
//  read: the tile store is read in S_RD first. Fill: each filled cell is
//  rewritten in S_FPOP and its four neighbors checked in S_FNB_RD/S_FNB_CHK;
//  S_FCLR then clears each visited mark. A fill that changes nothing ends in S_RD.
//  After reset a clearing pass over all 4096 cells empties the tile store;
//  items queue in the front end but none runs until it ends.
//  A stalled m_ready holds the back end; the front queue keeps two items.
// ----------------------------------------------------------------------------
module grid_flood_fill_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [1:0]                 s_kind,
    input  wire logic [gff_pkg::COL_W-1:0]  s_col,
    input  wire logic [gff_pkg::ROW_W-1:0]  s_row,
    input  wire logic [gff_pkg::VAL_W-1:0]  s_tile_value,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [gff_pkg::VAL_W-1:0]       m_read_value,
    output logic [gff_pkg::CNT_W-1:0]       m_cells_changed,
    output logic                            m_in_range,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic                       cfg_index,
    input  wire logic [gff_pkg::DIM_W-1:0]  cfg_data
);
    import gff_pkg::*;

    logic [DIM_W-1:0] map_width_reg, map_height_reg;
    logic [DIM_W-1:0] eff_w, eff_h;
    logic             q_valid, q_ready;
    cmd_t             q_cmd;

    assign cfg_ready = 1'b1;
    assign eff_w = (map_width_reg  < DIM_W'(MAX_COLS)) ? map_width_reg  : DIM_W'(MAX_COLS);
    assign eff_h = (map_height_reg < DIM_W'(MAX_ROWS)) ? map_height_reg : DIM_W'(MAX_ROWS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= DIM_W'(64);
            map_height_reg <= DIM_W'(64);
        end else if (cfg_valid) begin
            if (cfg_index == CFG_WIDTH) map_width_reg  <= cfg_data;
            else                        map_height_reg <= cfg_data;
        end
    end

    gff_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_col        (s_col),
        .s_row        (s_row),
        .s_tile_value (s_tile_value),
        .map_width    (eff_w),
        .map_height   (eff_h),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_ready      (q_ready)
    );

    gff_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .q_ready         (q_ready),
        .map_width       (eff_w),
        .map_height      (eff_h),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_value    (m_read_value),
        .m_cells_changed (m_cells_changed),
        .m_in_range      (m_in_range)
    );

endmodule
`default_nettype wire

[rtl/gff_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gff_front: command intake
// Checks each cell against the grid in use and queues a classified command.
// ----------------------------------------------------------------------------
module gff_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [1:0]                 s_kind,
    input  wire logic [gff_pkg::COL_W-1:0]  s_col,
    input  wire logic [gff_pkg::ROW_W-1:0]  s_row,
    input  wire logic [gff_pkg::VAL_W-1:0]  s_tile_value,
    input  wire logic [gff_pkg::DIM_W-1:0]  map_width,
    input  wire logic [gff_pkg::DIM_W-1:0]  map_height,
    output logic                            q_valid,
    output gff_pkg::cmd_t                   q_cmd,
    input  wire logic                       q_ready
);
    import gff_pkg::*;

    // Two-entry queue between the front and back ends.
    cmd_t       buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       cmd_in;
    logic       push, pop;

    always_comb begin
        cmd_in.kind     = s_kind;
        cmd_in.col      = s_col;
        cmd_in.row      = s_row;
        cmd_in.value    = s_tile_value;
        cmd_in.in_range = ({1'b0, s_col} < map_width) && ({1'b0, s_row} < map_height);
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = buf_reg[rd_ptr_reg];
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= cmd_in;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

[rtl/gff_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gff_back: command execution
// Owns the tile store, visited map and walk queue; runs writes, reads and
// breadth-first fills, and holds the result in an output register.
// ----------------------------------------------------------------------------
module gff_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       q_valid,
    input  wire gff_pkg::cmd_t              q_cmd,
    output logic                            q_ready,
    input  wire logic [gff_pkg::DIM_W-1:0]  map_width,
    input  wire logic [gff_pkg::DIM_W-1:0]  map_height,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [gff_pkg::VAL_W-1:0]       m_read_value,
    output logic [gff_pkg::CNT_W-1:0]       m_cells_changed,
    output logic                            m_in_range
);
    import gff_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_FSEED, S_FQRD, S_FPOP, S_FWAIT, S_FNB_RD, S_FNB_CHK,
        S_FCLR, S_OUT
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   sweep_reg;
    logic [ADDR_W-1:0]   addr_reg;       // cell being rewritten
    logic [ADDR_W-1:0]   nb_addr_reg;
    logic [1:0]          nb_idx_reg;
    logic                nb_ok_reg;
    logic [VAL_W-1:0]    target_reg, newval_reg;
    logic [QCNT_W-1:0]   head_reg, tail_reg;
    logic [CNT_W-1:0]    changed_reg;
    cmd_t                cmd_reg;

    // memories
    logic [VAL_W-1:0]    tile_mem [CELLS];
    logic                vis_mem  [CELLS];
    logic [ADDR_W-1:0]   wq_mem   [CELLS];
    logic [VAL_W-1:0]    tile_rd;
    logic                vis_rd;
    logic [ADDR_W-1:0]   wq_rd;

    logic                tile_we, vis_we, wq_we;
    logic [ADDR_W-1:0]   tile_wa, tile_ra, vis_wa, vis_ra, wq_wa, wq_ra;
    logic [VAL_W-1:0]    tile_wd;
    logic                vis_wd;

    logic [ADDR_W-1:0]   cmd_addr;
    logic [COL_W-1:0]    cur_col;
    logic [ROW_W-1:0]    cur_row;
    logic                nb_exists;
    logic [ADDR_W-1:0]   nb_addr;

    assign cmd_addr = {q_cmd.row, q_cmd.col};
    assign cur_col  = addr_reg[COL_W-1:0];
    assign cur_row  = addr_reg[ADDR_W-1:COL_W];
    assign q_ready  = (state_reg == S_IDLE);

    // neighbor order: right, left, down, up
    always_comb begin
        nb_exists = 1'b0;
        nb_addr   = addr_reg;
        case (nb_idx_reg)
            2'd0: begin
                nb_exists = ({1'b0, cur_col} + 7'd1) < map_width;
                nb_addr   = addr_reg + ADDR_W'(1);
            end
            2'd1: begin
                nb_exists = (cur_col != '0);
                nb_addr   = addr_reg - ADDR_W'(1);
            end
            2'd2: begin
                nb_exists = ({1'b0, cur_row} + 7'd1) < map_height;
                nb_addr   = addr_reg + ADDR_W'(MAX_COLS);
            end
            default: begin
                nb_exists = (cur_row != '0);
                nb_addr   = addr_reg - ADDR_W'(MAX_COLS);
            end
        endcase
    end

    // memory port control
    always_comb begin
        tile_we = 1'b0; tile_wa = addr_reg; tile_wd = newval_reg; tile_ra = nb_addr;
        vis_we  = 1'b0; vis_wa  = nb_addr_reg; vis_wd = 1'b1; vis_ra = nb_addr;
        wq_we   = 1'b0; wq_wa   = tail_reg[ADDR_W-1:0]; wq_ra = head_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_CLEAR: begin
                tile_we = 1'b1; tile_wa = sweep_reg; tile_wd = EMPTY_VAL;
                vis_we  = 1'b1; vis_wa  = sweep_reg; vis_wd  = 1'b0;
            end
            S_IDLE: begin
                tile_ra = cmd_addr;
                if (q_valid && q_cmd.in_range && q_cmd.kind == KIND_WRITE) begin
                    tile_we = 1'b1; tile_wa = cmd_addr; tile_wd = q_cmd.value;
                end
            end
            S_FSEED: begin
                vis_we = 1'b1; vis_wa = addr_reg; vis_wd = 1'b1;
                wq_we  = 1'b1; wq_wa = '0;
            end
            S_FPOP: begin
                tile_we = 1'b1;
            end
            S_FNB_CHK: begin
                if (nb_ok_reg && !vis_rd && tile_rd == target_reg) begin
                    vis_we = 1'b1;
                    wq_we  = 1'b1;
                end
            end
            S_FCLR: begin
                // wq_rd lags head by one entry; nothing to clear while head is still zero
                vis_we = (head_reg != '0); vis_wa = wq_rd; vis_wd = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tile_we) tile_mem[tile_wa] <= tile_wd;
        tile_rd <= tile_mem[tile_ra];
        if (vis_we) vis_mem[vis_wa] <= vis_wd;
        vis_rd <= vis_mem[vis_ra];
        if (wq_we) wq_mem[wq_wa] <= (state_reg == S_FSEED) ? addr_reg : nb_addr_reg;
        wq_rd <= wq_mem[wq_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            sweep_reg   <= '0;
            m_valid     <= 1'b0;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    sweep_reg <= sweep_reg + ADDR_W'(1);
                    if (sweep_reg == ADDR_W'(CELLS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg         <= q_cmd;
                        addr_reg        <= cmd_addr;
                        newval_reg      <= q_cmd.value;
                        m_read_value    <= EMPTY_VAL;
                        m_cells_changed <= '0;
                        m_in_range      <= q_cmd.in_range;
                        if (q_cmd.in_range && (q_cmd.kind == KIND_READ ||
                                               q_cmd.kind == KIND_FILL)) begin
                            state_reg <= S_RD;
                        end else begin
                            m_valid   <= 1'b1;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_RD: begin
                    if (cmd_reg.kind == KIND_READ) begin
                        m_read_value <= tile_rd;
                        m_valid      <= 1'b1;
                        state_reg    <= S_OUT;
                    end else if (tile_rd == newval_reg) begin
                        m_valid   <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        target_reg  <= tile_rd;
                        head_reg    <= '0;
                        tail_reg    <= QCNT_W'(1);
                        changed_reg <= '0;
                        state_reg   <= S_FSEED;
                    end
                end
                S_FSEED: begin
                    state_reg <= S_FQRD;
                end
                S_FQRD: begin
                    // let the last queue write settle before reading the head entry
                    state_reg <= S_FWAIT;
                end
                S_FWAIT: begin
                    // wq_rd now holds entry at head
                    if (head_reg == tail_reg) begin
                        m_cells_changed <= changed_reg;
                        head_reg        <= '0;
                        state_reg       <= S_FCLR;
                    end else begin
                        addr_reg  <= wq_rd;
                        head_reg  <= head_reg + QCNT_W'(1);
                        state_reg <= S_FPOP;
                    end
                end
                S_FPOP: begin
                    changed_reg <= changed_reg + CNT_W'(1);
                    nb_idx_reg  <= 2'd0;
                    state_reg   <= S_FNB_RD;
                end
                S_FNB_RD: begin
                    nb_ok_reg   <= nb_exists;
                    nb_addr_reg <= nb_addr;
                    state_reg   <= S_FNB_CHK;
                end
                S_FNB_CHK: begin
                    if (nb_ok_reg && !vis_rd && tile_rd == target_reg) begin
                        tail_reg <= tail_reg + QCNT_W'(1);
                    end
                    nb_idx_reg <= nb_idx_reg + 2'd1;
                    state_reg  <= (nb_idx_reg == 2'd3) ? S_FQRD : S_FNB_RD;
                end
                S_FCLR: begin
                    // walk queue entries again, clearing their visited marks
                    head_reg <= head_reg + QCNT_W'(1);
                    if (head_reg == tail_reg) begin
                        m_valid   <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[tb/sv/grid_flood_fill_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_flood_fill_core_tb: self-checking bench for the tile grid fill core
// Drives cell writes, reads and fills through the input channel while a
// behavioral copy of the grid predicts every result. Register writes sweep
// the grid size between phases, including empty and oversize settings.
// ----------------------------------------------------------------------------
module grid_flood_fill_core_tb;
    import gff_pkg::*;

    localparam kind_t KIND_SPARE   = 2'd3;
    localparam int    LIMIT_CYCLES = 20_000_000;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [CNT_W-1:0] cells_changed;
        logic             in_range;
    } grid_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic [COL_W-1:0]   s_col;
    logic [ROW_W-1:0]   s_row;
    logic [VAL_W-1:0]   s_tile_value;
    logic               m_valid;
    logic               m_ready;
    logic [VAL_W-1:0]   m_read_value;
    logic [CNT_W-1:0]   m_cells_changed;
    logic               m_in_range;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [DIM_W-1:0]   cfg_data;

    // Shadow grid and its size registers
    logic [VAL_W-1:0]   shadow_tiles [CELLS];
    bit                 fill_seen [CELLS];
    int unsigned        grid_cols;
    int unsigned        grid_rows;

    grid_result_t       pending_results [$];
    int                 mismatches;
    int                 results_seen;
    int                 fills_sent;
    int                 cfg_writes;
    int                 cycle_count;
    int                 rx_hold_left;
    bit                 tx_idle_en;
    bit                 rx_idle_en;

    grid_flood_fill_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_col           (s_col),
        .s_row           (s_row),
        .s_tile_value    (s_tile_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_value    (m_read_value),
        .m_cells_changed (m_cells_changed),
        .m_in_range      (m_in_range),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned used_cols();
        return (grid_cols < MAX_COLS) ? grid_cols : MAX_COLS;
    endfunction

    function automatic int unsigned used_rows();
        return (grid_rows < MAX_ROWS) ? grid_rows : MAX_ROWS;
    endfunction

    // Breadth-first fill on the shadow grid; returns cells rewritten
    function automatic int unsigned shadow_fill(int unsigned seed, logic [VAL_W-1:0] fill_val);
        int unsigned      walk [$];
        int unsigned      p;
        int unsigned      c;
        int unsigned      r;
        int unsigned      changed;
        logic [VAL_W-1:0] target;
        int unsigned      nbrs [$];
        target  = shadow_tiles[seed];
        changed = 0;
        if (target == fill_val)
            return 0;
        foreach (fill_seen[i]) fill_seen[i] = 0;
        fill_seen[seed] = 1;
        walk = {walk, seed};
        while (walk.size() != 0) begin
            p = walk.pop_front();
            c = p % MAX_COLS;
            r = p / MAX_COLS;
            shadow_tiles[p] = fill_val;
            changed++;
            nbrs.delete();
            if (c + 1 < used_cols()) nbrs = {nbrs, p + 1};
            if (c > 0) nbrs = {nbrs, p - 1};
            if (r + 1 < used_rows()) nbrs = {nbrs, p + MAX_COLS};
            if (r > 0) nbrs = {nbrs, p - MAX_COLS};
            foreach (nbrs[k]) begin
                if (!fill_seen[nbrs[k]] && shadow_tiles[nbrs[k]] == target) begin
                    fill_seen[nbrs[k]] = 1;
                    walk = {walk, nbrs[k]};
                end
            end
        end
        return changed;
    endfunction

    function automatic grid_result_t apply_command(kind_t k, logic [COL_W-1:0] c,
                                                   logic [ROW_W-1:0] r, logic [VAL_W-1:0] v);
        grid_result_t res;
        int unsigned  idx;
        res.read_value    = EMPTY_VAL;
        res.cells_changed = '0;
        res.in_range      = (c < used_cols()) && (r < used_rows());
        idx = r * MAX_COLS + c;
        if (res.in_range) begin
            case (k)
                KIND_WRITE: shadow_tiles[idx] = v;
                KIND_READ:  res.read_value = shadow_tiles[idx];
                KIND_FILL:  res.cells_changed = CNT_W'(shadow_fill(idx, v));
                default: ;
            endcase
        end
        return res;
    endfunction

    // Call at a falling edge; returns at a falling edge with valid low
    task automatic send_cmd(kind_t k, int unsigned c, int unsigned r, logic [VAL_W-1:0] v);
        if (tx_idle_en && $urandom_range(0, 99) < 16)
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        s_valid      = 1'b1;
        s_kind       = k;
        s_col        = COL_W'(c);
        s_row        = ROW_W'(r);
        s_tile_value = v;
        do @(posedge aclk); while (!s_ready);
        pending_results = {pending_results, apply_command(k, s_col, s_row, v)};
        if (k == KIND_FILL) fills_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        drain_results();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = DIM_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_WIDTH) grid_cols = val;
        else grid_rows = val;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_grid(int unsigned cols, int unsigned rows);
        write_reg(CFG_WIDTH, cols);
        write_reg(CFG_HEIGHT, rows);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        return ($urandom_range(0, 3) != 0) ? VAL_W'($urandom_range(0, 3))
                                           : VAL_W'($urandom);
    endfunction

    function automatic int unsigned pick_coord(int unsigned span);
        int unsigned top;
        top = (span + 1 > 63) ? 63 : span + 1;
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, top) : $urandom_range(0, 63);
    endfunction

    task automatic test_directed();
        tx_idle_en = 0;
        rx_idle_en = 0;
        send_cmd(KIND_WRITE, 0, 0, 11'd1023);
        send_cmd(KIND_WRITE, 63, 63, 11'h400);
        send_cmd(KIND_WRITE, 5, 0, 11'h2AA);
        send_cmd(KIND_READ, 0, 0, '0);
        send_cmd(KIND_READ, 63, 63, '0);
        send_cmd(KIND_READ, 20, 30, '0);
        send_cmd(KIND_SPARE, 7, 7, 11'd9);
        send_cmd(KIND_FILL, 10, 10, EMPTY_VAL);   // target already equals value
        send_cmd(KIND_FILL, 10, 10, 11'd5);       // sweeps nearly the whole grid
        send_cmd(KIND_READ, 62, 63, '0);
        set_grid(0, 64);
        send_cmd(KIND_WRITE, 0, 0, 11'd1);
        send_cmd(KIND_READ, 0, 0, '0);
        send_cmd(KIND_FILL, 0, 0, 11'd2);
        send_cmd(KIND_SPARE, 0, 0, '0);
        set_grid(127, 127);
        send_cmd(KIND_READ, 63, 0, '0);
        set_grid(1, 1);
        send_cmd(KIND_FILL, 0, 0, 11'd77);
        send_cmd(KIND_READ, 1, 0, '0);
        set_grid(3, 2);
        send_cmd(KIND_FILL, 2, 1, 11'd0);
        send_cmd(KIND_READ, 2, 1, '0);
        set_grid(64, 64);
        send_cmd(KIND_READ, 5, 0, '0);
    endtask

    task automatic test_random(int unsigned phases, int unsigned per_phase);
        int unsigned cols;
        int unsigned rows;
        int unsigned sel;
        int unsigned fill_pct;
        kind_t       k;
        for (int p = 0; p < phases; p++) begin
            sel  = $urandom_range(0, 9);
            cols = (sel == 0) ? $urandom_range(0, 127) : (sel == 1) ? 64 : $urandom_range(1, 12);
            sel  = $urandom_range(0, 9);
            rows = (sel == 0) ? $urandom_range(0, 127) : (sel == 1) ? 64 : $urandom_range(1, 12);
            set_grid(cols, rows);
            // keep big walks rare
            fill_pct   = (used_cols() * used_rows() > 256) ? 2 : 20;
            tx_idle_en = (p != 0);
            rx_idle_en = (p != 0);
            for (int i = 0; i < per_phase; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < fill_pct) k = KIND_FILL;
                else if (sel < 55) k = KIND_WRITE;
                else if (sel < 92) k = KIND_READ;
                else k = KIND_SPARE;
                send_cmd(k, pick_coord(used_cols()), pick_coord(used_rows()), pick_value());
            end
        end
    endtask

    task automatic test_backpressure();
        tx_idle_en   = 0;
        rx_hold_left = 300;
        for (int i = 0; i < 30; i++)
            send_cmd(($urandom_range(0, 1) != 0) ? KIND_WRITE : KIND_READ,
                     $urandom_range(0, 63), $urandom_range(0, 63), pick_value());
        drain_results();
        for (int i = 0; i < 20; i++)
            send_cmd(KIND_READ, $urandom_range(0, 63), $urandom_range(0, 63), '0);
        tx_idle_en = 1;
    endtask

    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            m_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            m_ready <= !(rx_idle_en && $urandom_range(0, 99) < 16);
        end
    end

    always @(posedge aclk) begin
        grid_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected transaction read=%h changed=%0d in_range=%b",
                             m_read_value, m_cells_changed, m_in_range);
            end else begin
                exp_res = pending_results.pop_front();
                if (m_read_value !== exp_res.read_value ||
                    m_cells_changed !== exp_res.cells_changed ||
                    m_in_range !== exp_res.in_range) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result %0d exp read=%h changed=%0d in_range=%b,",
                                  " got read=%h changed=%0d in_range=%b"},
                                 results_seen, exp_res.read_value, exp_res.cells_changed,
                                 exp_res.in_range, m_read_value, m_cells_changed, m_in_range);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_kind       = '0;
        s_col        = '0;
        s_row        = '0;
        s_tile_value = '0;
        cfg_valid    = 1'b0;
        cfg_index    = 1'b0;
        cfg_data     = '0;
        m_ready      = 1'b0;
        rx_hold_left = 0;
        tx_idle_en   = 0;
        rx_idle_en   = 0;
        mismatches   = 0;
        results_seen = 0;
        fills_sent   = 0;
        cfg_writes   = 0;
        cycle_count  = 0;
        grid_cols    = 64;
        grid_rows    = 64;
        foreach (shadow_tiles[i]) shadow_tiles[i] = EMPTY_VAL;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random(10, 100);
        test_backpressure();
        test_random(10, 100);

        drain_results();
        repeat (50) @(negedge aclk);
        $display("Covered %0d results, %0d fills and %0d register writes over %0d cycles,",
                 results_seen, fills_sent, cfg_writes, cycle_count);
        $display("with empty, tiny, full and oversize grids and output backpressure.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
